// File: design/itra_pkg.sv
// Shared types and constants for the integer to radix ASCII converter.
// No dependencies; every other design file refers to it by scoped names.
package itra_pkg;

  localparam int VALUE_W    = 64;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int MAX_DIGITS = 64;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int STEP_W     = 8;
  localparam int DIV_STEPS  = VALUE_W / STEP_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_DEC   = 5'd10;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_SHOW
  } itra_state_e;

  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] radix;
  } itra_div_ctl_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } itra_div_sts_t;

endpackage

// File: design/itra_if.sv
// Valid/ready channels of the converter: the integer input and the character output.
// Depends on itra_pkg for field widths.
interface itra_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [itra_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface itra_out_if;
  logic                        valid;
  logic                        ready;
  logic [itra_pkg::CHAR_W-1:0] ascii_char;
  logic                        last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// File: design/itra_div_unit.sv
// Iterative divider of a 64-bit word by a small radix, eight quotient bits per cycle.
// Depends on itra_pkg for widths and the control and status structs.
module itra_div_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itra_pkg::itra_div_ctl_t         ctl_i,
  input  logic [itra_pkg::VALUE_W-1:0]    dividend_i,
  output itra_pkg::itra_div_sts_t         sts_o,
  output logic [itra_pkg::VALUE_W-1:0]    quotient_o
);

  localparam logic [itra_pkg::STEP_CNT_W-1:0] LastStep =
    itra_pkg::STEP_CNT_W'(itra_pkg::DIV_STEPS - 1);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [itra_pkg::STEP_CNT_W-1:0]     cnt_q, cnt_d;
  logic [itra_pkg::VALUE_W-1:0]        work_q, work_d;
  logic [itra_pkg::DIGIT_W-1:0]        rem_q, rem_d;
  logic [itra_pkg::BASE_W-1:0]         radix_q, radix_d;
  logic [itra_pkg::DIGIT_W:0]          part;
  logic [itra_pkg::STEP_W-1:0]         qbits;

  always_comb begin
    part  = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < itra_pkg::STEP_W; i++) begin
      part = {part[itra_pkg::DIGIT_W-1:0], work_q[itra_pkg::VALUE_W-1-i]};
      if (part >= radix_q) begin
        part = part - radix_q;
        qbits[itra_pkg::STEP_W-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    work_d  = work_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    if (ctl_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      work_d  = dividend_i;
      rem_d   = '0;
      radix_d = ctl_i.radix;
    end else if (busy_q) begin
      work_d = {work_q[itra_pkg::VALUE_W-itra_pkg::STEP_W-1:0], qbits};
      rem_d  = part[itra_pkg::DIGIT_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;
  assign quotient_o = work_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a preceding busy cycle");

endmodule

// File: design/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter: sequencer, digit store, output.
// Depends on itra_pkg, the itra_in_if/itra_out_if channels and itra_div_unit.
//
//   channel  dir  payload                      handshake
//   cfg      in   cfg_wdata_i[4:0] (base)      cfg_we_i, no stall
//   in_i     in   value_in[63:0] signed        valid/ready
//   out_o    out  ascii_char[7:0], last_char   valid/ready
//
// Each digit takes a pass through the shared divider (load, eight 8-bit steps, store),
// then each character is read from the digit store and then shown; the sign needs no read.
// Base ten: up to 19 digits and a sign; base two: up to 64 digits.
// Reset clears the sequencer and sets the base to ten; the digit store is not cleared.
// A stalled output beat holds; no new value is taken until the last character leaves.
module integer_to_radix_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itra_pkg::BASE_W-1:0]   cfg_wdata_i,
  itra_in_if.sink                       in_i,
  itra_out_if.source                    out_o
);

  itra_pkg::itra_state_e               state_q, state_d;
  logic [itra_pkg::BASE_W-1:0]         base_q, base_d;
  logic [itra_pkg::VALUE_W-1:0]        mag_q, mag_d;
  logic                                minus_q, minus_d;
  logic [itra_pkg::CNT_W-1:0]          count_q, count_d;
  logic [itra_pkg::IDX_W-1:0]          rd_idx_q, rd_idx_d;
  logic [itra_pkg::DIGIT_W-1:0]        rd_data_q;
  logic [itra_pkg::DIGIT_W-1:0]        mem [itra_pkg::MAX_DIGITS];
  logic                                mem_we;
  logic                                div_last;
  logic [itra_pkg::VALUE_W-1:0]        quotient;
  itra_pkg::itra_div_ctl_t             div_ctl;
  itra_pkg::itra_div_sts_t             div_sts;

  itra_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (mag_q),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  assign div_last = (quotient == '0) ||
                    (count_q == itra_pkg::CNT_W'(itra_pkg::MAX_DIGITS - 1));

  always_comb begin
    base_d = base_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < itra_pkg::BASE_MIN) begin
        base_d = itra_pkg::BASE_MIN;
      end else if (cfg_wdata_i > itra_pkg::BASE_MAX) begin
        base_d = itra_pkg::BASE_MAX;
      end else begin
        base_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itra_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = itra_pkg::ST_LOAD;
      end
      itra_pkg::ST_LOAD: begin
        state_d = itra_pkg::ST_DIVIDE;
      end
      itra_pkg::ST_DIVIDE: begin
        if (div_sts.done) begin
          if (!div_last) begin
            state_d = itra_pkg::ST_LOAD;
          end else if (minus_q) begin
            state_d = itra_pkg::ST_SIGN;
          end else begin
            state_d = itra_pkg::ST_FETCH;
          end
        end
      end
      itra_pkg::ST_SIGN: begin
        if (out_o.ready) state_d = itra_pkg::ST_FETCH;
      end
      itra_pkg::ST_FETCH: begin
        state_d = itra_pkg::ST_SHOW;
      end
      itra_pkg::ST_SHOW: begin
        if (out_o.ready) begin
          state_d = (rd_idx_q == '0) ? itra_pkg::ST_IDLE : itra_pkg::ST_FETCH;
        end
      end
      default: state_d = itra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = 1'b0;
    out_o.valid      = 1'b0;
    out_o.ascii_char = itra_pkg::GLYPHS[rd_data_q];
    out_o.last_char  = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.radix    = base_q;
    mem_we           = 1'b0;
    mag_d            = mag_q;
    minus_d          = minus_q;
    count_d          = count_q;
    rd_idx_d         = rd_idx_q;
    unique case (state_q)
      itra_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          minus_d = (base_q == itra_pkg::BASE_DEC) && in_i.value_in[itra_pkg::VALUE_W-1];
          mag_d   = minus_d ? (~in_i.value_in + 1'b1) : in_i.value_in;
          count_d = '0;
        end
      end
      itra_pkg::ST_LOAD: begin
        div_ctl.start = 1'b1;
      end
      itra_pkg::ST_DIVIDE: begin
        if (div_sts.done) begin
          mem_we  = 1'b1;
          mag_d   = quotient;
          count_d = count_q + 1'b1;
          if (div_last) rd_idx_d = count_q[itra_pkg::IDX_W-1:0];
        end
      end
      itra_pkg::ST_SIGN: begin
        out_o.valid      = 1'b1;
        out_o.ascii_char = itra_pkg::CHAR_MINUS;
        if (out_o.ready) minus_d = 1'b0;
      end
      itra_pkg::ST_FETCH: begin
      end
      itra_pkg::ST_SHOW: begin
        out_o.valid     = 1'b1;
        out_o.last_char = (rd_idx_q == '0);
        if (out_o.ready && rd_idx_q != '0) rd_idx_d = rd_idx_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= itra_pkg::ST_IDLE;
      base_q   <= itra_pkg::BASE_DEC;
      minus_q  <= 1'b0;
      count_q  <= '0;
      mag_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      minus_q  <= minus_d;
      count_q  <= count_d;
      mag_q    <= mag_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[itra_pkg::IDX_W-1:0]] <= div_sts.rem;
    rd_data_q <= mem[rd_idx_q];
  end

  a_no_take_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while a character is pending");

  a_done_only_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == itra_pkg::ST_DIVIDE))
    else $error("divider result outside the divide state");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_char) |=> (state_q == itra_pkg::ST_IDLE))
    else $error("sequencer busy after the last character");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= itra_pkg::CNT_W'(itra_pkg::MAX_DIGITS))
    else $error("digit count beyond the store depth");

  a_sign_before_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itra_pkg::ST_SHOW) |-> !minus_q)
    else $error("digit shown while the minus sign is pending");

endmodule
